### src/rrad_pkg.sv
package rrad_pkg;

  localparam int VEL_WIDTH_DEF = 32;
  localparam int RAD_W = 32;
  localparam int CFG_W = 32;
  localparam int FORCE_W = 48;
  localparam int CFG_IDX_W = 3;

  // register indexes on the config channel
  localparam logic [CFG_IDX_W-1:0] CFG_AIR_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AIR_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AIR_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RE_SCALE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STOKES = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLEN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_NEWTON = 3'd6;

  // regime codes
  localparam logic [1:0] RGM_OFF = 2'd0;
  localparam logic [1:0] RGM_STOKES = 2'd1;
  localparam logic [1:0] RGM_ALLEN = 2'd2;
  localparam logic [1:0] RGM_NEWTON = 2'd3;

  localparam logic [63:0] RE2_LOW = 64'd4 << 32;
  localparam logic [63:0] RE2_HIGH = 64'd250000 << 32;
  localparam logic [63:0] FORCE_LIM = 64'h0000_8000_0000_0000;

  // stage boundaries of the pipeline
  localparam int ST_ROOT1 = 8;     // first shared root stage (|r| and re2)
  localparam int ROOT1_STEPS = 32;
  localparam int ST_ROOT2 = ST_ROOT1 + ROOT1_STEPS;
  localparam int ROOT2_STEPS = 24;
  localparam int ST_WSEL = ST_ROOT2 + ROOT2_STEPS;
  localparam int ST_DIV = ST_WSEL + 1;
  localparam int DIV_STEPS = 48;
  localparam int ST_OUT = ST_DIV + DIV_STEPS;
  localparam int N_STAGES = ST_OUT + 1;

  typedef struct packed {
    logic [CFG_W-1:0] air_x;
    logic [CFG_W-1:0] air_y;
    logic [CFG_W-1:0] air_z;
    logic [CFG_W-1:0] re_scale;
    logic [CFG_W-1:0] stokes;
    logic [CFG_W-1:0] allen;
    logic [CFG_W-1:0] newton;
  } cfg_t;

  typedef struct packed {
    logic [2:0][31:0]      r;
    logic [2:0]            fneg;
    logic [2:0][31:0]      u;
    logic [RAD_W-1:0]      rad;
    logic [63:0]           r2;
    logic [63:0]           sc;
    logic [2:0][63:0]      sq;
    logic [63:0]           s;
    logic [3:0][63:0]      pp;
    logic [63:0]           t;
    logic [63:0]           re2;
    logic [1:0]            rgm;
    logic                  dis;
    logic [63:0]           sn;
    logic [63:0]           sr;
    logic [63:0]           rn;
    logic [63:0]           rr;
    logic [55:0]           c;
    logic [2:0][1:0][63:0] spp;
    logic [2:0][47:0]      smag;
    logic [2:0][62:0]      p;
    logic [47:0]           wn;
    logic [47:0]           wr;
    logic [2:0][3:0][63:0] mpp;
    logic [2:0][127:0]     m;
    logic [2:0][63:0]      nmag;
    logic [2:0][79:0]      rem;
    logic [23:0]           w;
    logic [2:0]            asat;
    logic [2:0][47:0]      q;
    logic [2:0][FORCE_W-1:0] f;
  } pl_t;

endpackage

### src/reynolds_regime_air_drag.sv
// throughput: one beat per cycle; the depth comes from the two chained square
// root units (32 and 24 steps) and the 48-step quotient unit, one bit per stage
// a stall on the result side freezes every stage, nothing is dropped
// reset clears the stage valid bits and all config registers to zero
module reynolds_regime_air_drag
  import rrad_pkg::*;
#(
  parameter int VEL_WIDTH = VEL_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // vel_x, vel_y, vel_z, radius (lowest bit up), zero padded to bytes
  input  logic [((3*VEL_WIDTH+RAD_W+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // force_x, force_y, force_z
  output logic [3*FORCE_W-1:0] m_axis_tdata,
  // regime
  output logic [1:0] m_axis_tuser,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int VW = VEL_WIDTH;

  cfg_t cfg;
  logic [N_STAGES-1:0] vld;
  pl_t stg [N_STAGES];
  pl_t nx [N_STAGES];
  logic en;

  assign cfg_ready = 1'b1;
  assign en = !vld[N_STAGES-1] || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_AIR_X:    cfg.air_x <= cfg_data;
        CFG_AIR_Y:    cfg.air_y <= cfg_data;
        CFG_AIR_Z:    cfg.air_z <= cfg_data;
        CFG_RE_SCALE: cfg.re_scale <= cfg_data;
        CFG_STOKES:   cfg.stokes <= cfg_data;
        CFG_ALLEN:    cfg.allen <= cfg_data;
        CFG_NEWTON:   cfg.newton <= cfg_data;
        default: ;
      endcase
    end
  end

  // air velocity seen at the velocity width
  logic [2:0][VW-1:0] air_w;
  generate
    if (VW <= 32) begin : g_air_narrow
      assign air_w[0] = cfg.air_x[VW-1:0];
      assign air_w[1] = cfg.air_y[VW-1:0];
      assign air_w[2] = cfg.air_z[VW-1:0];
    end else begin : g_air_wide
      assign air_w[0] = {{(VW-32){1'b0}}, cfg.air_x};
      assign air_w[1] = {{(VW-32){1'b0}}, cfg.air_y};
      assign air_w[2] = {{(VW-32){1'b0}}, cfg.air_z};
    end
  endgenerate

  // stage 0: relative velocity, saturated to Q16.16
  always_comb begin
    logic signed [VW:0] d;
    logic signed [64:0] dx;
    nx[0] = stg[0];
    for (int i = 0; i < 3; i++) begin
      d = $signed({s_axis_tdata[i*VW+VW-1], s_axis_tdata[i*VW +: VW]})
        - $signed({air_w[i][VW-1], air_w[i]});
      dx = 65'(d);
      if (dx > 65'sd2147483647) nx[0].r[i] = 32'h7fff_ffff;
      else if (dx < -65'sd2147483648) nx[0].r[i] = 32'h8000_0000;
      else nx[0].r[i] = dx[31:0];
    end
    nx[0].rad = s_axis_tdata[3*VW +: RAD_W];
  end

  function automatic pl_t stage_step(input int k, input pl_t a, input cfg_t c);
    pl_t o;
    logic [127:0] w128;
    logic [95:0] w96;
    logic [63:0] b64;
    logic [63:0] coef;
    logic [63:0] mag;
    logic [63:0] lim;
    logic [47:0] b48;
    logic [79:0] dv;
    int j;
    o = a;
    if (k == 1) begin
      for (int i = 0; i < 3; i++) begin
        o.fneg[i] = !a.r[i][31] && (a.r[i] != '0);
        o.u[i] = a.r[i][31] ? (~a.r[i] + 32'd1) : a.r[i];
      end
      o.r2 = 64'(a.rad) * 64'(a.rad);
      o.sc = 64'(c.stokes) * 64'(a.rad);
    end
    if (k == 2) begin
      for (int i = 0; i < 3; i++) o.sq[i] = 64'(a.u[i]) * 64'(a.u[i]);
    end
    if (k == 3) o.s = a.sq[0] + a.sq[1] + a.sq[2];
    if (k == 4) begin
      o.pp[0] = 64'(a.s[31:0]) * 64'(a.r2[31:0]);
      o.pp[1] = 64'(a.s[31:0]) * 64'(a.r2[63:32]);
      o.pp[2] = 64'(a.s[63:32]) * 64'(a.r2[31:0]);
      o.pp[3] = 64'(a.s[63:32]) * 64'(a.r2[63:32]);
    end
    if (k == 5) begin
      w128 = 128'(a.pp[0]) + (128'(a.pp[1]) << 32) + (128'(a.pp[2]) << 32)
           + (128'(a.pp[3]) << 64);
      o.t = w128[127:64];
    end
    if (k == 6) begin
      o.pp[0] = 64'(c.re_scale) * 64'(a.t[31:0]);
      o.pp[1] = 64'(c.re_scale) * 64'(a.t[63:32]);
    end
    if (k == 7) begin
      w96 = 96'(a.pp[0]) + (96'(a.pp[1]) << 32);
      o.re2 = (|w96[95:88]) ? '1 : w96[87:24];
      if (o.re2 < RE2_LOW) o.rgm = RGM_STOKES;
      else if (o.re2 < RE2_HIGH) o.rgm = RGM_ALLEN;
      else o.rgm = RGM_NEWTON;
      o.dis = (c.stokes == '0) || (c.allen == '0) || (c.newton == '0);
      o.sn = a.s;
      o.sr = '0;
      o.rn = o.re2;
      o.rr = '0;
    end
    if (k == 8) begin
      coef = (a.rgm == RGM_ALLEN) ? 64'(c.allen) : 64'(c.newton);
      o.pp[0] = coef * 64'(a.r2[31:0]);
      o.pp[1] = coef * 64'(a.r2[63:32]);
    end
    if (k == 9) begin
      w96 = 96'(a.pp[0]) + (96'(a.pp[1]) << 32);
      o.c = w96[95:40];
    end
    if (k == 10) begin
      for (int i = 0; i < 3; i++) begin
        o.spp[i][0] = 64'(a.sc[31:0]) * 64'(a.u[i]);
        o.spp[i][1] = 64'(a.sc[63:32]) * 64'(a.u[i]);
      end
    end
    if (k == 11) begin
      for (int i = 0; i < 3; i++) begin
        w96 = 96'(a.spp[i][0]) + (96'(a.spp[i][1]) << 32);
        o.smag[i] = w96[95:48];
      end
    end
    // one root digit per stage for |r| and for sqrt(re2)
    if (k >= ST_ROOT1 && k < ST_ROOT1 + ROOT1_STEPS) begin
      j = k - ST_ROOT1;
      b64 = 64'd1 << (62 - 2*j);
      if (o.sn >= o.sr + b64) begin
        o.sn = o.sn - (o.sr + b64);
        o.sr = (o.sr >> 1) + b64;
      end else begin
        o.sr = o.sr >> 1;
      end
      if (o.rn >= o.rr + b64) begin
        o.rn = o.rn - (o.rr + b64);
        o.rr = (o.rr >> 1) + b64;
      end else begin
        o.rr = o.rr >> 1;
      end
    end
    if (k == ST_ROOT2) begin
      for (int i = 0; i < 3; i++) o.p[i] = 63'(64'(a.sr[31:0]) * 64'(a.u[i]));
      o.wn = {a.rr[31:0], 16'd0};
      o.wr = '0;
    end
    // second root: fourth root of re2 in Q8.16
    if (k >= ST_ROOT2 && k < ST_ROOT2 + ROOT2_STEPS) begin
      j = k - ST_ROOT2;
      b48 = 48'd1 << (46 - 2*j);
      if (o.wn >= o.wr + b48) begin
        o.wn = o.wn - (o.wr + b48);
        o.wr = (o.wr >> 1) + b48;
      end else begin
        o.wr = o.wr >> 1;
      end
    end
    if (k == ST_ROOT2 + 1) begin
      for (int i = 0; i < 3; i++) begin
        o.mpp[i][0] = 64'(a.c[31:0]) * 64'(a.p[i][31:0]);
        o.mpp[i][1] = 64'(a.c[31:0]) * 64'(a.p[i][62:32]);
        o.mpp[i][2] = 64'(a.c[55:32]) * 64'(a.p[i][31:0]);
        o.mpp[i][3] = 64'(a.c[55:32]) * 64'(a.p[i][62:32]);
      end
    end
    if (k == ST_ROOT2 + 2) begin
      for (int i = 0; i < 3; i++) begin
        o.m[i] = 128'(a.mpp[i][0]) + (128'(a.mpp[i][1]) << 32)
               + (128'(a.mpp[i][2]) << 32) + (128'(a.mpp[i][3]) << 64);
      end
    end
    if (k == ST_ROOT2 + 3) begin
      for (int i = 0; i < 3; i++) begin
        o.nmag[i] = a.m[i][119:56];
        o.rem[i] = a.m[i][119:40];
        o.q[i] = '0;
      end
    end
    if (k == ST_WSEL) begin
      o.w = (a.wr == '0) ? 24'd1 : a.wr[23:0];
      // quotient would not fit 48 bits
      for (int i = 0; i < 3; i++) o.asat[i] = a.rem[i] >= (80'(o.w) << 48);
    end
    if (k >= ST_DIV && k < ST_DIV + DIV_STEPS) begin
      j = DIV_STEPS - 1 - (k - ST_DIV);
      for (int i = 0; i < 3; i++) begin
        dv = 80'(a.w) << j;
        if (a.rem[i] >= dv) begin
          o.rem[i] = a.rem[i] - dv;
          o.q[i][j] = 1'b1;
        end
      end
    end
    if (k == ST_OUT) begin
      for (int i = 0; i < 3; i++) begin
        unique case (a.rgm)
          RGM_STOKES: mag = 64'(a.smag[i]);
          RGM_ALLEN:  mag = a.asat[i] ? '1 : 64'(a.q[i]);
          default:    mag = a.nmag[i];
        endcase
        lim = a.fneg[i] ? FORCE_LIM : FORCE_LIM - 64'd1;
        if (mag > lim) mag = lim;
        o.f[i] = a.fneg[i] ? FORCE_W'(~mag + 64'd1) : FORCE_W'(mag);
        if (a.dis) o.f[i] = '0;
      end
      if (a.dis) o.rgm = RGM_OFF;
    end
    return o;
  endfunction

  generate
    for (genvar k = 1; k < N_STAGES; k++) begin : g_stage
      always_comb nx[k] = stage_step(k, stg[k-1], cfg);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[N_STAGES-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N_STAGES; k++) stg[k] <= nx[k];
    end
  end

  assign m_axis_tvalid = vld[N_STAGES-1];
  assign m_axis_tdata = {stg[N_STAGES-1].f[2], stg[N_STAGES-1].f[1], stg[N_STAGES-1].f[0]};
  assign m_axis_tuser = stg[N_STAGES-1].rgm;

  a_off_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == RGM_OFF) |-> (m_axis_tdata == '0))
    else $error("disabled regime with nonzero force");

  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a blocked result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule
